// ===== src/crcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, constants and the crc32 byte step for the packet deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  // default number of steppers carried by a target packet
  localparam int STEPPERS_DEFAULT = 4;

  // crc32 (ieee, reflected)
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // sync pair
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // message types
  localparam logic [7:0] TYPE_TARGET    = 8'h01;
  localparam logic [7:0] TYPE_HEARTBEAT = 8'h02;

  // reset value of the payload limit
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  // header layout: type, 4 bytes seq, 8 bytes stamp, 2 bytes length
  localparam logic [15:0] HDR_POS_TYPE   = 16'd0;
  localparam logic [15:0] HDR_POS_SEQ_HI = 16'd4;
  localparam logic [15:0] HDR_POS_TS_HI  = 16'd12;
  localparam logic [15:0] HDR_POS_LEN_LO = 16'd13;
  localparam logic [15:0] HDR_POS_LEN_HI = 16'd14;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TARGET    = 3'd0,
    KIND_HEARTBEAT = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_LEN_ERR   = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_OVERSIZE  = 3'd5
  } kind_t;

  // one finished packet, as handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic [7:0]  ptype;
  } cmd_t;

  // one byte through the reflected crc32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== src/crcdf_byte_if.sv =====
// ----------------------------------------------------------------------------
// crcdf_byte_if
// Received byte channel: valid, ready and one serial byte.
// ----------------------------------------------------------------------------
interface crcdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/crcdf_result_if.sv =====
// ----------------------------------------------------------------------------
// crcdf_result_if
// Result channel: valid, ready and one target or status word.
// ----------------------------------------------------------------------------
interface crcdf_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  index;
  logic [31:0] target_bits;
  logic [31:0] seq;
  logic [63:0] stamp;
  logic [7:0]  packet_type;
  logic        last;

  modport source (output valid, output kind, output index, output target_bits, output seq,
                  output stamp, output packet_type, output last, input ready);
  modport sink (input valid, input kind, input index, input target_bits, input seq,
                input stamp, input packet_type, input last, output ready);
endinterface

// ===== src/crcdf_front.sv =====
// ----------------------------------------------------------------------------
// crcdf_front
// Sync hunt, header capture, crc32 and payload store; one byte a cycle while
// the queue has room. Pushes one command per packet end into the queue.
// ----------------------------------------------------------------------------
module crcdf_front #(
  parameter int STEPPERS = crcdf_pkg::STEPPERS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  crcdf_byte_if.sink                rx,
  input  logic                      q_full,
  output logic                      push,
  output crcdf_pkg::cmd_t           push_cmd,
  output logic [STEPPERS*32-1:0]    push_words
);
  import crcdf_pkg::*;

  localparam int KEEP_LEN = STEPPERS * 4;
  localparam int KW       = $clog2(KEEP_LEN);

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] max_payload;
  logic [15:0] byte_count;
  logic [31:0] crc_acc;
  logic [7:0]  type_reg;
  logic [31:0] seq_reg;
  logic [63:0] stamp_reg;
  logic [15:0] length_reg;
  logic [31:0] rx_crc_reg;
  logic [7:0]  store [KEEP_LEN];

  logic        take;
  logic [7:0]  b;
  logic [31:0] crc_step;
  logic        hdr_end;
  logic        pay_end;
  logic        crc_end;
  logic [15:0] len_full;
  logic        crc_bad;
  logic        push_req;
  kind_t       push_kind;

  assign rx.ready = !q_full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign crc_step = crc_byte(crc_acc, b);
  assign hdr_end  = (byte_count == HDR_POS_LEN_HI);
  assign pay_end  = ((byte_count + 16'd1) == length_reg);
  assign crc_end  = (byte_count[1:0] == 2'd3);
  assign len_full = {b, length_reg[7:0]};
  assign crc_bad  = ((crc_acc ^ CRC_INIT) != {b, rx_crc_reg[31:8]});

  // payload limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT0;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  // next phase and packet end classification
  always_comb begin
    phase_next = phase;
    push_req   = 1'b0;
    push_kind  = KIND_UNKNOWN;
    case (phase)
      PH_HUNT0: begin
        if (b == SYNC_FIRST) phase_next = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b == SYNC_SECOND) begin
          phase_next = PH_HEADER;
        end else if (b != SYNC_FIRST) begin
          phase_next = PH_HUNT0;
        end
      end
      PH_HEADER: begin
        if (hdr_end) begin
          if (len_full > max_payload) begin
            phase_next = PH_HUNT0;
            push_req   = 1'b1;
            push_kind  = KIND_OVERSIZE;
          end else if (len_full == 16'd0) begin
            phase_next = PH_CRC;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_end) phase_next = PH_CRC;
      end
      PH_CRC: begin
        if (crc_end) begin
          phase_next = PH_HUNT0;
          push_req   = 1'b1;
          if (crc_bad) begin
            push_kind = KIND_CRC_ERR;
          end else if (type_reg == TYPE_TARGET) begin
            push_kind = (length_reg == 16'(KEEP_LEN)) ? KIND_TARGET : KIND_LEN_ERR;
          end else if (type_reg == TYPE_HEARTBEAT) begin
            push_kind = KIND_HEARTBEAT;
          end else begin
            push_kind = KIND_UNKNOWN;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT0;
      end
    endcase
  end

  // header fields, counters and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 16'd0;
      crc_acc    <= CRC_INIT;
      type_reg   <= 8'd0;
      seq_reg    <= 32'd0;
      stamp_reg  <= 64'd0;
      length_reg <= 16'd0;
      rx_crc_reg <= 32'd0;
    end else if (take) begin
      case (phase)
        PH_HUNT1: begin
          if (b == SYNC_SECOND) begin
            byte_count <= 16'd0;
            crc_acc    <= CRC_INIT;
          end
        end
        PH_HEADER: begin
          crc_acc <= crc_step;
          if (byte_count == HDR_POS_TYPE) begin
            type_reg   <= b;
            seq_reg    <= 32'd0;
            stamp_reg  <= 64'd0;
            length_reg <= 16'd0;
          end else if (byte_count <= HDR_POS_SEQ_HI) begin
            seq_reg <= {b, seq_reg[31:8]};
          end else if (byte_count <= HDR_POS_TS_HI) begin
            stamp_reg <= {b, stamp_reg[63:8]};
          end else if (byte_count == HDR_POS_LEN_LO) begin
            length_reg <= {8'd0, b};
          end else begin
            length_reg <= len_full;
          end
          if (hdr_end) begin
            byte_count <= 16'd0;
            rx_crc_reg <= 32'd0;
          end else begin
            byte_count <= byte_count + 16'd1;
          end
        end
        PH_PAYLOAD: begin
          crc_acc <= crc_step;
          if (pay_end) begin
            byte_count <= 16'd0;
            rx_crc_reg <= 32'd0;
          end else begin
            byte_count <= byte_count + 16'd1;
          end
        end
        PH_CRC: begin
          rx_crc_reg <= {b, rx_crc_reg[31:8]};
          byte_count <= crc_end ? 16'd0 : byte_count + 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // first payload bytes kept for the target words
  always_ff @(posedge clk) begin
    if (take && phase == PH_PAYLOAD && byte_count < 16'(KEEP_LEN)) begin
      store[byte_count[KW-1:0]] <= b;
    end
  end

  // command towards the back
  assign push           = take && push_req;
  assign push_cmd.kind  = push_kind;
  assign push_cmd.seq   = seq_reg;
  assign push_cmd.stamp = stamp_reg;
  assign push_cmd.ptype = type_reg;

  for (genvar i = 0; i < STEPPERS; i++) begin : g_words
    assign push_words[i*32 +: 32] = {store[4*i+3], store[4*i+2], store[4*i+1], store[4*i]};
  end

endmodule

// ===== src/crcdf_queue.sv =====
// ----------------------------------------------------------------------------
// crcdf_queue
// Short first-in first-out queue of packet commands between front and back.
// ----------------------------------------------------------------------------
module crcdf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = crcdf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import crcdf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/crcdf_back.sv =====
// ----------------------------------------------------------------------------
// crcdf_back
// Turns one packet command into its result words: one per stepper for a
// target packet, a single status word otherwise. Registered output.
// ----------------------------------------------------------------------------
module crcdf_back #(
  parameter int STEPPERS = crcdf_pkg::STEPPERS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [$bits(crcdf_pkg::cmd_t)+STEPPERS*32-1:0] q_data,
  output logic                                 q_pop,
  crcdf_result_if.source                       res
);
  import crcdf_pkg::*;

  localparam int SW = (STEPPERS > 1) ? $clog2(STEPPERS) : 1;

  logic          active;
  cmd_t          cur_cmd;
  logic [31:0]   cur_words [STEPPERS];
  logic [SW-1:0] step;

  logic          out_valid;
  logic [2:0]    out_kind;
  logic [3:0]    out_index;
  logic [31:0]   out_bits;
  logic [31:0]   out_seq;
  logic [63:0]   out_stamp;
  logic [7:0]    out_type;
  logic          out_last;

  logic          load_out;
  logic          emit;
  logic          is_target;
  logic          final_step;
  cmd_t          q_cmd;

  assign q_cmd      = q_data[$bits(cmd_t)+STEPPERS*32-1 -: $bits(cmd_t)];
  assign load_out   = !out_valid || res.ready;
  assign emit       = active && load_out;
  assign is_target  = (cur_cmd.kind == KIND_TARGET);
  assign final_step = !is_target || (step == SW'(STEPPERS - 1));
  assign q_pop      = !active && !q_empty;

  // current command
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (q_pop) begin
      active <= 1'b1;
      step   <= '0;
    end else if (emit) begin
      if (final_step) begin
        active <= 1'b0;
      end else begin
        step <= step + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd <= q_cmd;
      for (int i = 0; i < STEPPERS; i++) begin
        cur_words[i] <= q_data[i*32 +: 32];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= cur_cmd.kind;
      out_index <= is_target ? 4'(step) : 4'd0;
      out_bits  <= is_target ? cur_words[step] : 32'd0;
      out_seq   <= cur_cmd.seq;
      out_stamp <= cur_cmd.stamp;
      out_type  <= cur_cmd.ptype;
      out_last  <= final_step;
    end
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_kind;
  assign res.index       = out_index;
  assign res.target_bits = out_bits;
  assign res.seq         = out_seq;
  assign res.stamp       = out_stamp;
  assign res.packet_type = out_type;
  assign res.last        = out_last;

endmodule

// ===== src/sync_crc32_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_crc32_packet_deframer
// Sync word packet deframer with crc32 check and stepper target unpacking.
// ----------------------------------------------------------------------------
//  channel  direction  words per packet            contents
//  rx       in         2 sync + 15 header + n + 4  one received byte
//  res      out        STEPPERS or 1               target or status result
//  cfg      in         -                           max_payload, 16 bits
//
// the front takes one byte per cycle; crc and field capture are one byte step
// the first result word passes the command queue, current command register
// and output register; it waits while the back is busy with an earlier packet
// a target packet gives STEPPERS words on consecutive cycles while res is ready
// rx stalls only while the two-entry command queue is full
// rst is synchronous; the block is ready for bytes in the cycle after it
// ----------------------------------------------------------------------------
module sync_crc32_packet_deframer #(
  parameter int STEPPERS = crcdf_pkg::STEPPERS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  crcdf_byte_if.sink     rx,
  crcdf_result_if.source res
);
  import crcdf_pkg::*;

  localparam int QW = $bits(cmd_t) + STEPPERS * 32;

  logic                   push;
  cmd_t                   push_cmd;
  logic [STEPPERS*32-1:0] push_words;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  logic [QW-1:0]          q_data;

  // parse and check
  crcdf_front #(.STEPPERS(STEPPERS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_words  (push_words)
  );

  // packet commands
  crcdf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cmd, push_words}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // result words
  crcdf_back #(.STEPPERS(STEPPERS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ===== src/crcdf_checker.sv =====
// ----------------------------------------------------------------------------
// crcdf_checker
// Port level checks on the result channel of the packet deframer.
// ----------------------------------------------------------------------------
module crcdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [3:0]  index,
  input logic [31:0] target_bits,
  input logic        last
);
  import crcdf_pkg::*;

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // status words are single, with no stepper data
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TARGET |-> last && index == 4'd0 && target_bits == 32'd0)
    else $error("status word with stepper fields");

  // only defined result kinds
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_OVERSIZE)
    else $error("undefined result kind");

  // target words of a packet follow back to back with rising index
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_TARGET && !last
    |=> out_valid && kind == KIND_TARGET && index == $past(index) + 4'd1)
    else $error("target burst broken");

endmodule

bind sync_crc32_packet_deframer crcdf_checker u_crcdf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .kind        (res.kind),
  .index       (res.index),
  .target_bits (res.target_bits),
  .last        (res.last)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the sync word packet deframer. Frames are built here with their own
// crc32 and fed one byte per word. A predictor rebuilds every target and
// status word from the accepted bytes. Each result word is compared field by
// field, in order. Both channels idle at random, and the payload limit is
// changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crcdf_pkg::*;

  localparam int STEPPERS         = STEPPERS_DEFAULT;
  localparam int KEEP_BYTES       = 4 * STEPPERS;
  localparam int MAX_GAP          = 16;
  localparam int CFG_SETTLE       = 8;
  localparam int END_SETTLE       = 32;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_BYTES     = 60;
  localparam int RANDOM_RESULTS   = 4;
  localparam int FRAMES_PER_PHASE = 3;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef enum {
    FR_TARGET,
    FR_HEARTBEAT,
    FR_UNKNOWN,
    FR_LEN_ERR,
    FR_CRC_ERR,
    FR_OVERSIZE,
    FR_TRUNCATED,
    FR_NOISE
  } frame_pick_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  index;
    logic [31:0] target_bits;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic [7:0]  ptype;
    logic        last;
  } deframe_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  crcdf_byte_if   rx_if ();
  crcdf_result_if res_if ();

  sync_crc32_packet_deframer #(
    .STEPPERS(STEPPERS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rx         (rx_if),
    .res        (res_if)
  );

  // predictor state
  phase_t      fr_phase  = PH_HUNT0;
  logic [15:0] fr_count  = '0;
  logic [31:0] fr_crc    = CRC_INIT;
  logic [7:0]  fr_type   = '0;
  logic [31:0] fr_seq    = '0;
  logic [63:0] fr_stamp  = '0;
  logic [15:0] fr_len    = '0;
  logic [31:0] fr_rx_crc = '0;
  logic [15:0] fr_limit  = MAX_PAYLOAD_RESET;
  logic [7:0]  fr_keep [KEEP_BYTES];

  deframe_result_t predicted_results[$];
  logic [7:0]      tx_bytes[$];

  bit rx_calm  = 1'b0;
  bit res_calm = 1'b0;

  int mismatch_count  = 0;
  int predicted_count = 0;
  int checked_count   = 0;
  int target_count    = 0;
  int bytes_accepted  = 0;
  int limit_writes    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reflected crc32, one data bit per step
  function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ data[k]}});
    end
    return c;
  endfunction

  function automatic void push_result(input kind_t k, input int idx, input logic [31:0] bits,
                                      input bit fin);
    deframe_result_t r;
    r.kind        = k;
    r.index       = idx[3:0];
    r.target_bits = bits;
    r.seq         = fr_seq;
    r.stamp       = fr_stamp;
    r.ptype       = fr_type;
    r.last        = fin;
    predicted_results.push_back(r);
    predicted_count++;
  endfunction

  // advance the deframer model by one received byte
  function automatic void deframe_byte(input logic [7:0] b);
    int pos;
    pos = int'(fr_count);
    case (fr_phase)
      PH_HUNT0: begin
        if (b == SYNC_FIRST) fr_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b == SYNC_SECOND) begin
          fr_phase = PH_HEADER;
          fr_count = '0;
          fr_crc   = CRC_INIT;
        end else if (b != SYNC_FIRST) begin
          fr_phase = PH_HUNT0;
        end
      end
      PH_HEADER: begin
        fr_crc = crc32_next(fr_crc, b);
        if (pos == HDR_POS_TYPE) begin
          fr_type  = b;
          fr_seq   = '0;
          fr_stamp = '0;
          fr_len   = '0;
        end else if (pos <= HDR_POS_SEQ_HI) begin
          fr_seq[8*(pos-1) +: 8] = b;
        end else if (pos <= HDR_POS_TS_HI) begin
          fr_stamp[8*(pos-int'(HDR_POS_SEQ_HI)-1) +: 8] = b;
        end else if (pos == HDR_POS_LEN_LO) begin
          fr_len[7:0] = b;
        end else begin
          fr_len[15:8] = b;
        end
        // header complete: limit check, then payload or straight to crc
        if (pos == HDR_POS_LEN_HI) begin
          fr_count  = '0;
          fr_rx_crc = '0;
          if (fr_len > fr_limit) begin
            fr_phase = PH_HUNT0;
            push_result(KIND_OVERSIZE, 0, '0, 1'b1);
          end else begin
            fr_phase = (fr_len == 0) ? PH_CRC : PH_PAYLOAD;
          end
        end else begin
          fr_count = fr_count + 16'd1;
        end
      end
      PH_PAYLOAD: begin
        fr_crc = crc32_next(fr_crc, b);
        if (pos < KEEP_BYTES) fr_keep[pos] = b;
        fr_count = fr_count + 16'd1;
        if (fr_count == fr_len) begin
          fr_count  = '0;
          fr_rx_crc = '0;
          fr_phase  = PH_CRC;
        end
      end
      PH_CRC: begin
        fr_rx_crc[8*pos +: 8] = b;
        if (pos < 3) begin
          fr_count = fr_count + 16'd1;
        end else begin
          fr_count = '0;
          fr_phase = PH_HUNT0;
          // packet end: crc first, then type and length
          if ((fr_crc ^ CRC_INIT) != fr_rx_crc) begin
            push_result(KIND_CRC_ERR, 0, '0, 1'b1);
          end else if (fr_type == TYPE_TARGET) begin
            if (fr_len != KEEP_BYTES) begin
              push_result(KIND_LEN_ERR, 0, '0, 1'b1);
            end else begin
              for (int s = 0; s < STEPPERS; s++) begin
                push_result(KIND_TARGET, s, {fr_keep[4*s+3], fr_keep[4*s+2],
                                             fr_keep[4*s+1], fr_keep[4*s]},
                            s == STEPPERS - 1);
              end
            end
          end else if (fr_type == TYPE_HEARTBEAT) begin
            push_result(KIND_HEARTBEAT, 0, '0, 1'b1);
          end else begin
            push_result(KIND_UNKNOWN, 0, '0, 1'b1);
          end
        end
      end
      default: begin
        fr_phase = PH_HUNT0;
      end
    endcase
  endfunction

  // feed the predictor with every accepted byte
  always @(posedge clk) begin
    if (!rst && rx_if.valid && rx_if.ready) begin
      deframe_byte(rx_if.rx_byte);
      bytes_accepted++;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    deframe_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result word with none predicted: kind %0d index %0d seq %0h",
               res_if.kind, res_if.index, res_if.seq);
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("kind", want.kind, res_if.kind);
        check_field("index", want.index, res_if.index);
        check_field("target_bits", want.target_bits, res_if.target_bits);
        check_field("seq", want.seq, res_if.seq);
        check_field("stamp", want.stamp, res_if.stamp);
        check_field("packet_type", want.ptype, res_if.packet_type);
        check_field("last", want.last, res_if.last);
        checked_count++;
        if (want.kind == KIND_TARGET) target_count++;
      end
    end
  end

  // result side back-pressure, a fresh stall for every word
  initial begin : res_pacing
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = res_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // watchdog: no word moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, predicted_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // send one byte after a random gap, wait for acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  task automatic send_bytes();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // append sync pair and header, then payload and crc unless hdr_only
  task automatic add_frame(input logic [7:0] ptype, input logic [31:0] seq,
                           input logic [63:0] stamp, input logic [15:0] len,
                           input fill_t fill, input bit hdr_only, input bit bad_crc);
    logic [7:0]  body[$];
    logic [31:0] crc;
    body.push_back(ptype);
    for (int i = 0; i < 4; i++) body.push_back(seq[8*i +: 8]);
    for (int i = 0; i < 8; i++) body.push_back(stamp[8*i +: 8]);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (!hdr_only) begin
      for (int i = 0; i < int'(len); i++) begin
        body.push_back(fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hFF : 8'($urandom));
      end
    end
    crc = CRC_INIT;
    foreach (body[i]) crc = crc32_next(crc, body[i]);
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(SYNC_SECOND);
    foreach (body[i]) tx_bytes.push_back(body[i]);
    if (!hdr_only) begin
      for (int i = 0; i < 4; i++) tx_bytes.push_back(crc[8*i +: 8]);
    end
  endtask

  // limit change only once the block has gone quiet
  task automatic write_max_payload(input logic [15:0] v);
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fr_limit = v;
    limit_writes++;
  endtask

  // target packets with extreme, then random, header and payload values
  task automatic test_targets();
    rx_calm  = 1'b1;
    res_calm = 1'b1;
    add_frame(TYPE_TARGET, 32'h0, 64'h0, KEEP_BYTES, FILL_ZERO, 1'b0, 1'b0);
    add_frame(TYPE_TARGET, '1, '1, KEEP_BYTES, FILL_ONES, 1'b0, 1'b0);
    send_bytes();
    rx_calm  = 1'b0;
    res_calm = 1'b0;
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
              1'b0, 1'b0);
    send_bytes();
  endtask

  // heartbeat, unknown, length and crc error outcomes, frames back to back
  task automatic test_status_words();
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, 0, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, 5, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(8'h00, $urandom, {$urandom, $urandom}, 3, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(8'hFF, $urandom, {$urandom, $urandom}, 0, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, 0, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES - 1, FILL_RANDOM,
              1'b0, 1'b0);
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES + 1, FILL_RANDOM,
              1'b0, 1'b0);
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
              1'b0, 1'b1);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, 2, FILL_RANDOM, 1'b0, 1'b1);
    send_bytes();
  endtask

  // stray second byte, broken pair, repeated first byte
  task automatic test_sync_hunt();
    tx_bytes.push_back(SYNC_SECOND);
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(8'h12);
    tx_bytes.push_back(SYNC_FIRST);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, 1, FILL_RANDOM, 1'b0, 1'b0);
    send_bytes();
  endtask

  // payload limit at its extremes and on the boundary
  task automatic test_payload_limit();
    write_max_payload(16'h0000);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, 0, FILL_RANDOM, 1'b0, 1'b0);
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
              1'b1, 1'b0);
    add_frame(8'h07, $urandom, {$urandom, $urandom}, 16'hFFFF, FILL_RANDOM, 1'b1, 1'b0);
    send_bytes();
    write_max_payload(16'(KEEP_BYTES));
    add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
              1'b0, 1'b0);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, KEEP_BYTES + 1, FILL_RANDOM,
              1'b1, 1'b0);
    send_bytes();
    write_max_payload(16'hFFFF);
    add_frame(8'h80, $urandom, {$urandom, $urandom}, 40, FILL_RANDOM, 1'b0, 1'b0);
    send_bytes();
    write_max_payload(MAX_PAYLOAD_RESET);
    add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom}, MAX_PAYLOAD_RESET + 1,
              FILL_RANDOM, 1'b1, 1'b0);
    send_bytes();
  endtask

  // mostly well-formed frames, some broken ones and noise, limit per phase
  task automatic test_random_stream();
    int          first_result;
    int          stream_bytes;
    int          r;
    int          len;
    int          cut;
    frame_pick_t pick;
    logic [7:0]  ptype;
    logic [15:0] limit;
    first_result = predicted_count;
    stream_bytes = 0;
    while (stream_bytes < RANDOM_BYTES || predicted_count - first_result < RANDOM_RESULTS) begin
      case ($urandom_range(0, 4))
        0:       limit = 16'hFFFF;
        1:       limit = 16'(KEEP_BYTES);
        2:       limit = 16'($urandom_range(0, 24));
        3:       limit = 16'($urandom_range(25, 65534));
        default: limit = MAX_PAYLOAD_RESET;
      endcase
      write_max_payload(limit);
      repeat (FRAMES_PER_PHASE) begin
        rx_calm  = ($urandom_range(0, 3) == 0);
        res_calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 30)      pick = FR_TARGET;
        else if (r < 45) pick = FR_HEARTBEAT;
        else if (r < 55) pick = FR_UNKNOWN;
        else if (r < 65) pick = FR_LEN_ERR;
        else if (r < 75) pick = FR_CRC_ERR;
        else if (r < 85) pick = FR_OVERSIZE;
        else if (r < 92) pick = FR_TRUNCATED;
        else             pick = FR_NOISE;
        // no oversize possible at the top limit; keep cut frames short
        if (pick == FR_OVERSIZE && limit == 16'hFFFF) pick = FR_HEARTBEAT;
        if (pick == FR_TRUNCATED && limit > MAX_PAYLOAD_RESET) pick = FR_CRC_ERR;
        case (pick)
          FR_TARGET: begin
            add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
                      1'b0, 1'b0);
          end
          FR_HEARTBEAT: begin
            add_frame(TYPE_HEARTBEAT, $urandom, {$urandom, $urandom},
                      16'($urandom_range(0, 24)), FILL_RANDOM, 1'b0, 1'b0);
          end
          FR_UNKNOWN: begin
            do ptype = 8'($urandom); while (ptype == TYPE_TARGET || ptype == TYPE_HEARTBEAT);
            add_frame(ptype, $urandom, {$urandom, $urandom}, 16'($urandom_range(0, 24)),
                      FILL_RANDOM, 1'b0, 1'b0);
          end
          FR_LEN_ERR: begin
            do len = $urandom_range(0, 24); while (len == KEEP_BYTES);
            add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, 16'(len), FILL_RANDOM,
                      1'b0, 1'b0);
          end
          FR_CRC_ERR: begin
            add_frame(8'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                      16'($urandom_range(0, 24)), FILL_RANDOM, 1'b0, 1'b1);
          end
          FR_OVERSIZE: begin
            if ($urandom_range(0, 1) == 0) len = int'(limit) + 1;
            else len = $urandom_range(int'(limit) + 1, 65535);
            add_frame(8'($urandom), $urandom, {$urandom, $urandom}, 16'(len), FILL_RANDOM,
                      1'b1, 1'b0);
          end
          FR_TRUNCATED: begin
            add_frame(TYPE_TARGET, $urandom, {$urandom, $urandom}, KEEP_BYTES, FILL_RANDOM,
                      1'b0, 1'b0);
            cut = $urandom_range(1, tx_bytes.size() - 1);
            repeat (cut) void'(tx_bytes.pop_back());
          end
          default: begin
            repeat ($urandom_range(1, 8)) begin
              tx_bytes.push_back(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
            end
          end
        endcase
        if (pick != FR_NOISE) stream_bytes += tx_bytes.size();
        send_bytes();
      end
    end
  endtask

  // main sequence
  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_targets();
    test_status_words();
    test_sync_hunt();
    test_payload_limit();
    test_random_stream();

    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    $display("run covered %0d bytes and %0d result words (%0d target, %0d status)",
             bytes_accepted, checked_count, target_count, checked_count - target_count);
    $display("payload limit set %0d times, sync hunt, all status kinds and limit edges",
             limit_writes);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/crcdf_pkg.sv
src/crcdf_byte_if.sv
src/crcdf_result_if.sv
src/crcdf_front.sv
src/crcdf_queue.sv
src/crcdf_back.sv
src/sync_crc32_packet_deframer.sv
src/crcdf_checker.sv
tb/tb_top.sv
